/* src/mrbb_pkg.sv */
package mrbb_pkg;

   localparam int MAX_WIDTH_DEF  = 64;
   localparam int MAX_HEIGHT_DEF = 64;

   localparam int NEIGHBORS = 8;

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_SCAN   = 2'd1,
      OP_READ   = 2'd2,
      OP_UNUSED = 2'd3
   } op_type;

   typedef enum logic {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_type;

   function automatic int nb_dx(input logic [2:0] i);
      case (i)
         3'd0: return 0;
         3'd1: return 1;
         3'd2: return 1;
         3'd3: return 1;
         3'd4: return 0;
         default: return -1;
      endcase
   endfunction

   function automatic int nb_dy(input logic [2:0] i);
      case (i)
         3'd0: return -1;
         3'd1: return -1;
         3'd2: return 0;
         3'd3: return 1;
         3'd4: return 1;
         3'd5: return 1;
         3'd6: return 0;
         default: return -1;
      endcase
   endfunction

endpackage

/* src/mrbb_ram.sv */
module mrbb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

/* src/mrbb_grow.sv */
module mrbb_grow #(
   parameter int XW = 6,
   parameter int YW = 6,
   parameter int DW = 7,
   parameter int DH = 7
) (
   input  logic [XW-1:0] box_x,
   input  logic [YW-1:0] box_y,
   input  logic [DW-1:0] box_w,
   input  logic [DH-1:0] box_h,
   input  logic [XW-1:0] pt_x,
   input  logic [YW-1:0] pt_y,
   output logic [XW-1:0] new_x,
   output logic [YW-1:0] new_y,
   output logic [DW-1:0] new_w,
   output logic [DH-1:0] new_h
);

   int nx, ny, rx, ry;

   always_comb begin
      nx = (int'(box_x) < int'(pt_x)) ? int'(box_x) : int'(pt_x);
      ny = (int'(box_y) < int'(pt_y)) ? int'(box_y) : int'(pt_y);
      rx = (int'(box_x) + int'(box_w) > int'(pt_x) + 1) ?
           int'(box_x) + int'(box_w) : int'(pt_x) + 1;
      ry = (int'(box_y) + int'(box_h) > int'(pt_y) + 1) ?
           int'(box_y) + int'(box_h) : int'(pt_y) + 1;
      new_x = XW'(nx);
      new_y = YW'(ny);
      new_w = DW'(rx - nx);
      new_h = DH'(ry - ny);
   end

endmodule

/* src/mask_region_bounding_boxes_unit.sv */
// Holds a binary mask and finds bounding boxes of its set regions. Each request
// transaction writes one pixel, runs a scan, or reads one box, and returns one
// response carrying the current region count. Only one request is in work at a
// time. The response to a pixel write or an unused operation is valid in the cycle
// after the accept, that of a box read after a further S_RD_WAIT state. A scan
// first sweeps the label memory, then walks the area one pixel at a time through a
// single label/mask memory port: a clear pixel takes S_PIX_RD and S_PIX_EV; a set
// pixel adds S_BOX_LD if already labeled, S_NB_RD for each neighbor, S_NB_EV for
// each in-bounds one and S_BOX_WR, sequenced through one box-growth unit; the scan
// response is loaded from S_DONE after the walk. After reset the block clears the
// mask and label memories before it accepts a request; configuration writes are
// taken at any time.
module mask_region_bounding_boxes_unit
   import mrbb_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [6:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pixel_x[5:0], pixel_y[11:6], bit_value[12], region_index[24:13], zero pad
   input  logic [31:0] req_tdata,
   // operation[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // region_count[12:0], box_x[18:13], box_y[24:19], box_w[31:25],
   // box_h[38:32], zero pad
   output logic [39:0] rsp_tdata,
   // request_error[0]
   output logic        rsp_tuser
);

   localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CW    = $clog2(CELLS + 1);
   localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int DW    = $clog2(MAX_WIDTH + 1);
   localparam int DH    = $clog2(MAX_HEIGHT + 1);
   localparam int BW    = XW + YW + DW + DH;

   typedef enum logic [3:0] {
      S_IDLE, S_CLEAR, S_PIX_RD, S_PIX_EV, S_BOX_LD,
      S_NB_RD, S_NB_EV, S_BOX_WR, S_RD_WAIT, S_DONE
   } state_type;

   state_type       state_ff;
   logic            clr_mask_ff;
   logic [AW-1:0]   clr_addr_ff;
   logic [DW-1:0]   x_ff;
   logic [DH-1:0]   y_ff;
   logic [2:0]      nb_ff;
   logic [AW-1:0]   nb_addr_ff;
   logic [XW-1:0]   nb_x_ff;
   logic [YW-1:0]   nb_y_ff;
   logic [CW-1:0]   cur_ff;
   logic [AW-1:0]   box_idx_ff;
   logic [XW-1:0]   bx_ff;
   logic [YW-1:0]   by_ff;
   logic [DW-1:0]   bw_ff;
   logic [DH-1:0]   bh_ff;
   logic [CW-1:0]   count_ff;
   logic [6:0]      width_ff;
   logic [6:0]      height_ff;
   logic            rd_err_ff;
   logic            rsp_valid_ff;
   logic [12:0]     rsp_count_ff;
   logic [5:0]      rsp_x_ff;
   logic [5:0]      rsp_y_ff;
   logic [6:0]      rsp_w_ff;
   logic [6:0]      rsp_h_ff;
   logic            rsp_err_ff;

   logic [DW-1:0]   eff_w;
   logic [DH-1:0]   eff_h;
   logic [5:0]      req_x;
   logic [5:0]      req_y;
   logic            req_bit;
   logic [11:0]     req_ri;
   op_type          req_op;
   logic            req_fire;
   logic            wr_ok;
   logic [AW-1:0]   wr_pix_addr;
   logic [AW-1:0]   pix_addr;
   int              ax, ay;
   logic            nb_in;
   logic [AW-1:0]   nb_addr;
   logic            adv_last;
   logic [DW-1:0]   x_adv;
   logic [DH-1:0]   y_adv;
   logic            rsp_load;

   logic            mask_we, mask_wd, mask_rd;
   logic [AW-1:0]   mask_wa, ml_ra;
   logic            label_we;
   logic [AW-1:0]   label_wa;
   logic [CW-1:0]   label_wd, label_rd;
   logic            box_we;
   logic [AW-1:0]   box_ra;
   logic [BW-1:0]   box_rd;
   logic [XW-1:0]   g_x;
   logic [YW-1:0]   g_y;
   logic [DW-1:0]   g_w;
   logic [DH-1:0]   g_h;

   assign req_x   = req_tdata[5:0];
   assign req_y   = req_tdata[11:6];
   assign req_bit = req_tdata[12];
   assign req_ri  = req_tdata[24:13];
   assign req_op  = op_type'(req_tuser);

   assign eff_w = (32'(width_ff) > 32'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(width_ff);
   assign eff_h = (32'(height_ff) > 32'(MAX_HEIGHT)) ? DH'(MAX_HEIGHT) : DH'(height_ff);

   assign req_tready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;

   assign wr_ok = (32'(req_x) < 32'(eff_w)) && (32'(req_y) < 32'(eff_h));
   assign wr_pix_addr = AW'(int'(req_y) * MAX_WIDTH + int'(req_x));
   assign pix_addr    = AW'(int'(y_ff) * MAX_WIDTH + int'(x_ff));

   always_comb begin
      ax = int'(x_ff) + nb_dx(nb_ff);
      ay = int'(y_ff) + nb_dy(nb_ff);
      nb_in = (ax >= 0) && (ax < int'(eff_w)) && (ay >= 0) && (ay < int'(eff_h));
      nb_addr = AW'(ay * MAX_WIDTH + ax);
   end

   always_comb begin
      adv_last = (int'(x_ff) + 1 == int'(eff_w)) && (int'(y_ff) + 1 == int'(eff_h));
      if (int'(x_ff) + 1 == int'(eff_w)) begin
         x_adv = '0;
         y_adv = DH'(int'(y_ff) + 1);
      end else begin
         x_adv = DW'(int'(x_ff) + 1);
         y_adv = y_ff;
      end
   end

   always_comb begin
      mask_we = 1'b0;
      mask_wa = clr_addr_ff;
      mask_wd = 1'b0;
      if (state_ff == S_CLEAR && clr_mask_ff) begin
         mask_we = 1'b1;
      end else if (req_fire && req_op == OP_WRITE && wr_ok) begin
         mask_we = 1'b1;
         mask_wa = wr_pix_addr;
         mask_wd = req_bit;
      end
      ml_ra = (state_ff == S_NB_RD) ? nb_addr : pix_addr;
      label_we = 1'b0;
      label_wa = clr_addr_ff;
      label_wd = '0;
      if (state_ff == S_CLEAR) begin
         label_we = 1'b1;
      end else if (state_ff == S_NB_EV && mask_rd) begin
         label_we = 1'b1;
         label_wa = nb_addr_ff;
         label_wd = cur_ff;
      end
      box_we = (state_ff == S_BOX_WR);
      box_ra = (state_ff == S_PIX_EV) ? AW'(label_rd - CW'(1)) : AW'(req_ri);
   end

   mrbb_ram #(.WIDTH(1), .DEPTH(CELLS)) u_mask (
      .clock(clock), .wr_en(mask_we), .wr_addr(mask_wa), .wr_data(mask_wd),
      .rd_addr(ml_ra), .rd_data(mask_rd)
   );

   mrbb_ram #(.WIDTH(CW), .DEPTH(CELLS)) u_label (
      .clock(clock), .wr_en(label_we), .wr_addr(label_wa), .wr_data(label_wd),
      .rd_addr(ml_ra), .rd_data(label_rd)
   );

   mrbb_ram #(.WIDTH(BW), .DEPTH(CELLS)) u_box (
      .clock(clock), .wr_en(box_we), .wr_addr(box_idx_ff),
      .wr_data({bh_ff, bw_ff, by_ff, bx_ff}),
      .rd_addr(box_ra), .rd_data(box_rd)
   );

   mrbb_grow #(.XW(XW), .YW(YW), .DW(DW), .DH(DH)) u_grow (
      .box_x(bx_ff), .box_y(by_ff), .box_w(bw_ff), .box_h(bh_ff),
      .pt_x(nb_x_ff), .pt_y(nb_y_ff),
      .new_x(g_x), .new_y(g_y), .new_w(g_w), .new_h(g_h)
   );

   assign rsp_load = (req_fire && (req_op == OP_WRITE || req_op == OP_UNUSED))
                     || state_ff == S_RD_WAIT || state_ff == S_DONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_mask_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         count_ff     <= '0;
         width_ff     <= 7'd64;
         height_ff    <= 7'd64;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_type'(csr_index))
               CSR_WIDTH:  width_ff  <= csr_wdata;
               CSR_HEIGHT: height_ff <= csr_wdata;
               default:    width_ff  <= width_ff;
            endcase
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  rsp_count_ff <= 13'(count_ff);
                  rsp_x_ff     <= '0;
                  rsp_y_ff     <= '0;
                  rsp_w_ff     <= '0;
                  rsp_h_ff     <= '0;
                  case (req_op)
                     OP_WRITE: rsp_err_ff <= !wr_ok;
                     OP_SCAN: begin
                        count_ff    <= '0;
                        clr_mask_ff <= 1'b0;
                        clr_addr_ff <= '0;
                        state_ff    <= S_CLEAR;
                     end
                     OP_READ: begin
                        rd_err_ff <= !(32'(req_ri) < 32'(count_ff));
                        state_ff  <= S_RD_WAIT;
                     end
                     default: rsp_err_ff <= 1'b1;
                  endcase
               end
            end
            S_CLEAR: begin
               clr_addr_ff <= clr_addr_ff + AW'(1);
               if (clr_addr_ff == AW'(CELLS - 1)) begin
                  x_ff <= '0;
                  y_ff <= '0;
                  if (clr_mask_ff) begin
                     state_ff <= S_IDLE;
                  end else if (eff_w == '0 || eff_h == '0) begin
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_PIX_RD;
                  end
               end
            end
            S_PIX_RD: state_ff <= S_PIX_EV;
            S_PIX_EV: begin
               nb_ff <= '0;
               if (!mask_rd) begin
                  x_ff     <= x_adv;
                  y_ff     <= y_adv;
                  state_ff <= adv_last ? S_DONE : S_PIX_RD;
               end else if (label_rd == '0) begin
                  bx_ff      <= XW'(x_ff);
                  by_ff      <= YW'(y_ff);
                  bw_ff      <= DW'(1);
                  bh_ff      <= DH'(1);
                  box_idx_ff <= AW'(count_ff);
                  count_ff   <= count_ff + CW'(1);
                  cur_ff     <= count_ff + CW'(1);
                  state_ff   <= S_NB_RD;
               end else begin
                  box_idx_ff <= AW'(label_rd - CW'(1));
                  cur_ff     <= label_rd;
                  state_ff   <= S_BOX_LD;
               end
            end
            S_BOX_LD: begin
               {bh_ff, bw_ff, by_ff, bx_ff} <= box_rd;
               state_ff <= S_NB_RD;
            end
            S_NB_RD: begin
               nb_addr_ff <= nb_addr;
               nb_x_ff    <= XW'(ax);
               nb_y_ff    <= YW'(ay);
               if (nb_in) begin
                  state_ff <= S_NB_EV;
               end else begin
                  nb_ff    <= nb_ff + 3'd1;
                  state_ff <= (nb_ff == 3'(NEIGHBORS - 1)) ? S_BOX_WR : S_NB_RD;
               end
            end
            S_NB_EV: begin
               if (mask_rd && label_rd == '0) begin
                  bx_ff <= g_x;
                  by_ff <= g_y;
                  bw_ff <= g_w;
                  bh_ff <= g_h;
               end
               nb_ff    <= nb_ff + 3'd1;
               state_ff <= (nb_ff == 3'(NEIGHBORS - 1)) ? S_BOX_WR : S_NB_RD;
            end
            S_BOX_WR: begin
               x_ff     <= x_adv;
               y_ff     <= y_adv;
               state_ff <= adv_last ? S_DONE : S_PIX_RD;
            end
            S_RD_WAIT: begin
               rsp_err_ff <= rd_err_ff;
               if (!rd_err_ff) begin
                  rsp_x_ff <= 6'(box_rd[XW-1:0]);
                  rsp_y_ff <= 6'(box_rd[XW+YW-1:XW]);
                  rsp_w_ff <= 7'(box_rd[XW+YW+DW-1:XW+YW]);
                  rsp_h_ff <= 7'(box_rd[BW-1:XW+YW+DW]);
               end
               state_ff <= S_IDLE;
            end
            S_DONE: begin
               rsp_count_ff <= 13'(count_ff);
               rsp_err_ff   <= 1'b0;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_h_ff, rsp_w_ff, rsp_y_ff, rsp_x_ff, rsp_count_ff};
   assign rsp_tuser  = rsp_err_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("response overwritten before it was taken");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= CELLS)
      else $error("region count exceeds the cell count");

   a_scan_clears: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_op == OP_SCAN) |=> (state_ff == S_CLEAR && count_ff == '0))
      else $error("scan did not start with a label sweep");

   a_label_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_NB_EV && label_we) |-> (cur_ff != '0))
      else $error("neighbor labeled with an empty region");

endmodule

/* tb/tb.sv */
module tb;
   import mrbb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      op_type     op;
      logic [5:0] px;
      logic [5:0] py;
      logic       bit_val;
      logic [11:0] ridx;
   } mask_req_type;

   typedef struct {
      logic [12:0] count;
      logic [5:0]  bx;
      logic [5:0]  by;
      logic [6:0]  bw;
      logic [6:0]  bh;
      logic        err;
   } box_rsp_type;

   localparam int CELLS = 64 * 64;
   localparam int WATCHDOG_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic        csr_index = CSR_WIDTH;
   logic [6:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [1:0]  req_tuser = OP_WRITE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tuser;

   mask_region_bounding_boxes_unit DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow state of the block.
   logic [6:0] width_reg = 7'd64;
   logic [6:0] height_reg = 7'd64;
   bit   mask_img [CELLS];
   int   label_map [CELLS];
   int   box_x0 [CELLS];
   int   box_y0 [CELLS];
   int   box_wd [CELLS];
   int   box_ht [CELLS];
   int   region_total = 0;

   const int step_dx [8] = '{0, 1, 1, 1, 0, -1, -1, -1};
   const int step_dy [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};

   mask_req_type pending_q [$];
   box_rsp_type  expected_q [$];
   int  n_items = 0;
   int  n_checked = 0;
   int  n_scans = 0;
   int  n_errors = 0;
   bit  calm = 1'b0;
   bit  hold_req = 1'b0;
   int  hold_cnt = 0;
   int  quiet_cycles = 0;

   function automatic int eff_w();
      return (width_reg > 64) ? 64 : int'(width_reg);
   endfunction

   function automatic int eff_h();
      return (height_reg > 64) ? 64 : int'(height_reg);
   endfunction

   function automatic void label_regions();
      int w, h, cur, ax, ay, idx, nx, ny, rx, ry;
      w = eff_w();
      h = eff_h();
      foreach (label_map[k]) label_map[k] = 0;
      region_total = 0;
      for (int y = 0; y < h; y++) begin
         for (int x = 0; x < w; x++) begin
            if (!mask_img[y * 64 + x]) continue;
            cur = label_map[y * 64 + x];
            if (cur == 0) begin
               box_x0[region_total] = x;
               box_y0[region_total] = y;
               box_wd[region_total] = 1;
               box_ht[region_total] = 1;
               region_total++;
               cur = region_total;
            end
            for (int i = 0; i < 8; i++) begin
               ax = x + step_dx[i];
               ay = y + step_dy[i];
               if (ax < 0 || ax >= w || ay < 0 || ay >= h) continue;
               idx = ay * 64 + ax;
               if (!mask_img[idx]) continue;
               if (label_map[idx] == 0) begin
                  nx = (box_x0[cur-1] < ax) ? box_x0[cur-1] : ax;
                  ny = (box_y0[cur-1] < ay) ? box_y0[cur-1] : ay;
                  rx = (box_x0[cur-1] + box_wd[cur-1] > ax + 1) ?
                       box_x0[cur-1] + box_wd[cur-1] : ax + 1;
                  ry = (box_y0[cur-1] + box_ht[cur-1] > ay + 1) ?
                       box_y0[cur-1] + box_ht[cur-1] : ay + 1;
                  box_x0[cur-1] = nx;
                  box_y0[cur-1] = ny;
                  box_wd[cur-1] = rx - nx;
                  box_ht[cur-1] = ry - ny;
               end
               label_map[idx] = cur;
            end
         end
      end
   endfunction

   function automatic box_rsp_type predict_response(mask_req_type r);
      box_rsp_type e;
      e = '{count: '0, bx: '0, by: '0, bw: '0, bh: '0, err: 1'b0};
      case (r.op)
         OP_WRITE: begin
            if (r.px < eff_w() && r.py < eff_h())
               mask_img[r.py * 64 + r.px] = r.bit_val;
            else
               e.err = 1'b1;
         end
         OP_SCAN: begin
            label_regions();
            n_scans++;
         end
         OP_READ: begin
            if (r.ridx < region_total) begin
               e.bx = 6'(box_x0[r.ridx]);
               e.by = 6'(box_y0[r.ridx]);
               e.bw = 7'(box_wd[r.ridx]);
               e.bh = 7'(box_ht[r.ridx]);
            end else begin
               e.err = 1'b1;
            end
         end
         default: e.err = 1'b1;
      endcase
      e.count = 13'(region_total);
      return e;
   endfunction

   // Request driver.
   always @(posedge clock) begin
      mask_req_type cur;
      bit offer;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_q.push_back(predict_response(pending_q.pop_front()));
         end
         offer = pending_q.size() > 0 &&
                 ((req_tvalid && !req_tready) || calm || $urandom_range(99) >= 11);
         if (offer) begin
            cur = pending_q[0];
            req_tdata <= {7'd0, cur.ridx, cur.bit_val, cur.py, cur.px};
            req_tuser <= cur.op;
         end
         req_tvalid <= offer;
      end
   end

   // Response monitor and checker.
   always @(posedge clock) begin
      box_rsp_type e;
      box_rsp_type a;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            a.count = rsp_tdata[12:0];
            a.bx = rsp_tdata[18:13];
            a.by = rsp_tdata[24:19];
            a.bw = rsp_tdata[31:25];
            a.bh = rsp_tdata[38:32];
            a.err = rsp_tuser;
            if (expected_q.size() == 0) begin
               $error("response transaction with no request outstanding");
               n_errors++;
            end else begin
               e = expected_q.pop_front();
               n_checked++;
               if (a.count !== e.count) begin
                  $error("region_count expected %0d actual %0d", e.count, a.count);
                  n_errors++;
               end
               if (a.bx !== e.bx) begin
                  $error("box_x expected %0d actual %0d", e.bx, a.bx);
                  n_errors++;
               end
               if (a.by !== e.by) begin
                  $error("box_y expected %0d actual %0d", e.by, a.by);
                  n_errors++;
               end
               if (a.bw !== e.bw) begin
                  $error("box_w expected %0d actual %0d", e.bw, a.bw);
                  n_errors++;
               end
               if (a.bh !== e.bh) begin
                  $error("box_h expected %0d actual %0d", e.bh, a.bh);
                  n_errors++;
               end
               if (a.err !== e.err) begin
                  $error("request_error expected %0d actual %0d", e.err, a.err);
                  n_errors++;
               end
            end
         end
         if (hold_req && hold_cnt == 0) begin
            hold_cnt <= 300;
            hold_req <= 1'b0;
            rsp_tready <= 1'b0;
         end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || $urandom_range(99) >= 11;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   task automatic push_req(op_type op, int x, int y, bit b, int ri);
      mask_req_type r;
      r.op = op;
      r.px = 6'(x);
      r.py = 6'(y);
      r.bit_val = b;
      r.ridx = 12'(ri);
      pending_q.push_back(r);
      n_items++;
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_q.size() != 0 || req_tvalid || expected_q.size() != 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_size(int w, int h);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= CSR_WIDTH;
      csr_wdata <= 7'(w);
      @(posedge clock);
      csr_index <= CSR_HEIGHT;
      csr_wdata <= 7'(h);
      @(posedge clock);
      csr_we <= 1'b0;
      width_reg = 7'(w);
      height_reg = 7'(h);
   endtask

   function automatic int coord(int lim);
      if (lim == 0 || $urandom_range(99) < 10) return $urandom_range(63);
      return $urandom_range(lim - 1);
   endfunction

   initial begin
      int w, h, n_big;
      foreach (mask_img[k]) mask_img[k] = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part, first at full size, then at 5x3 and at the sizes 0x127 and 127x0.
      push_req(OP_READ, 0, 0, 0, 0);
      push_req(OP_UNUSED, 63, 63, 1, 4095);
      push_req(OP_WRITE, 0, 0, 1, 0);
      push_req(OP_WRITE, 63, 63, 1, 0);
      push_req(OP_WRITE, 63, 0, 1, 0);
      push_req(OP_WRITE, 62, 1, 1, 0);
      push_req(OP_WRITE, 1, 1, 1, 4095);
      push_req(OP_SCAN, 0, 0, 0, 0);
      for (int i = 0; i < 5; i++) push_req(OP_READ, 0, 0, 0, i);
      push_req(OP_READ, 63, 63, 1, 4095);
      push_req(OP_WRITE, 1, 1, 0, 0);
      drain();
      hold_req = 1'b1;
      set_size(5, 3);
      push_req(OP_WRITE, 5, 0, 1, 0);
      push_req(OP_WRITE, 0, 3, 1, 0);
      push_req(OP_WRITE, 4, 2, 1, 0);
      push_req(OP_SCAN, 0, 0, 0, 0);
      push_req(OP_READ, 0, 0, 0, 0);
      push_req(OP_READ, 0, 0, 0, 1);
      drain();
      set_size(0, 127);
      push_req(OP_WRITE, 0, 0, 1, 0);
      push_req(OP_SCAN, 0, 0, 0, 0);
      push_req(OP_READ, 0, 0, 0, 0);
      drain();
      set_size(127, 0);
      push_req(OP_SCAN, 0, 0, 0, 0);
      drain();

      // Random phases of pixel writes with occasional random operations, then a scan and box reads.
      n_big = 0;
      while (n_items < 900) begin
         if (n_big < 2 && $urandom_range(19) == 0) begin
            w = 64;
            h = ($urandom_range(1)) ? 64 : 127;
            n_big++;
         end else begin
            w = $urandom_range(1, 12);
            h = $urandom_range(1, 12);
            if ($urandom_range(9) == 0) w = $urandom_range(1) ? 0 : 127;
         end
         set_size(w, h);
         calm = (n_items < 100) || ($urandom_range(7) == 0);
         if ($urandom_range(9) == 0) hold_req = 1'b1;
         repeat ($urandom_range(5, 30)) begin
            if ($urandom_range(99) < 8)
               push_req(op_type'($urandom_range(3)), $urandom_range(63),
                        $urandom_range(63), $urandom_range(1), $urandom_range(4095));
            else
               push_req(OP_WRITE, coord(eff_w()), coord(eff_h()),
                        $urandom_range(99) < 80, $urandom_range(4095));
         end
         push_req(OP_SCAN, $urandom_range(63), $urandom_range(63),
                  $urandom_range(1), $urandom_range(4095));
         for (int i = 0; i <= $urandom_range(8); i++)
            push_req(OP_READ, $urandom_range(63), $urandom_range(63),
                     $urandom_range(1), i);
         push_req(OP_READ, 0, 0, 0, $urandom_range(4095));
         drain();
         calm = 1'b0;
      end

      $display("Checked %0d responses over %0d requests, including %0d scans,",
               n_checked, n_items, n_scans);
      $display("across several mask sizes with random stalls on both channels.");
      if (n_errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

/* filelist.f */
src/mrbb_pkg.sv
src/mrbb_ram.sv
src/mrbb_grow.sv
src/mask_region_bounding_boxes_unit.sv
tb/tb.sv
